>>> rtl/pbpp_pkg.sv
// ----------------------------------------------------------------------------
// pbpp_pkg: shared types and constants
// Record field codes, status codes and field widths for the progress parser.
// ----------------------------------------------------------------------------
package pbpp_pkg;

  // Record field that the parser is in.
  typedef enum logic [3:0] {
    PH_VERSION  = 4'd0,
    PH_EXTLEN   = 4'd1,
    PH_EXTSKIP  = 4'd2,
    PH_HASHLEN  = 4'd3,
    PH_HASHSKIP = 4'd4,
    PH_PIECE    = 4'd5,
    PH_TOTAL    = 4'd6,
    PH_UPLOAD   = 4'd7,
    PH_MAPLEN   = 4'd8,
    PH_MAP      = 4'd9,
    PH_COUNT    = 4'd10,
    PH_EIDX     = 4'd11,
    PH_ELEN     = 4'd12,
    PH_EMLEN    = 4'd13,
    PH_EMAP     = 4'd14,
    PH_SINK     = 4'd15
  } phase_t;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_VERSION   = 3'd1;
  localparam logic [2:0] ST_TRUNCATED = 3'd2;
  localparam logic [2:0] ST_ZERO_LEN  = 3'd3;
  localparam logic [2:0] ST_MAP_LARGE = 3'd4;

  // Number of bytes in a fixed-width field.
  function automatic logic [3:0] field_width(input phase_t p);
    logic [3:0] w;
    w = 4'd4;
    if (p == PH_VERSION) w = 4'd2;
    if (p == PH_TOTAL || p == PH_UPLOAD) w = 4'd8;
    return w;
  endfunction

endpackage

>>> rtl/pbpp_span8.sv
// ----------------------------------------------------------------------------
// pbpp_span8: eight clipped spans of one bitmap byte
// Adds the clipped sizes of the set bits of one byte, MSB first, and gives
// the saturated offset that follows the byte.
// ----------------------------------------------------------------------------
module pbpp_span8 (
  input  logic [63:0] base,
  input  logic [31:0] step,
  input  logic [63:0] limit,
  input  logic [31:0] size,
  input  logic [7:0]  bits,
  output logic [34:0] sum,
  output logic [63:0] next_base
);
  import pbpp_pkg::*;

  logic [66:0] off_raw [8];
  logic [63:0] off     [8];
  logic [63:0] room    [8];
  logic [31:0] span    [8];
  logic [66:0] end_raw;

  // Offsets of the eight slots are independent, so all are formed at once.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      off_raw[k] = {3'b000, base} + 67'(35'(k) * {3'b000, step});
      off[k]     = (|off_raw[k][66:64]) ? '1 : off_raw[k][63:0];
      room[k]    = limit - off[k];
      if (off[k] >= limit || !bits[7-k]) begin
        span[k] = '0;
      end else if ({32'd0, size} < room[k]) begin
        span[k] = size;
      end else begin
        span[k] = room[k][31:0];
      end
    end
  end

  // Sum of the slot sizes.
  always_comb begin
    sum = '0;
    for (int k = 0; k < 8; k++) begin
      sum = sum + {3'b000, span[k]};
    end
  end

  // Offset after all eight slots, saturating.
  assign end_raw   = {3'b000, base} + {32'd0, step, 3'b000};
  assign next_base = (|end_raw[66:64]) ? '1 : end_raw[63:0];

endmodule

>>> rtl/piece_bitmap_progress_parser.sv
// ----------------------------------------------------------------------------
// piece_bitmap_progress_parser: download control record progress parser
// Parses a control record byte by byte, stores the completed-piece bitmap
// and reports a status and the downloaded byte count on the last byte.
// ----------------------------------------------------------------------------
// Channel  Dir  Transfer   Contents
// s_*      in   one byte   tdata[7:0] data_byte, tlast last_byte
// m_*      out  one result tdata[2:0] status, tdata[66:3] done_bytes
//
// One byte is taken in every cycle; the bitmap byte sum is one pass of
// eight parallel clipped spans between the input and the state registers.
// A result is registered into a two-entry output buffer on its last byte;
// the buffer lets input continue while a result waits.
// Reset is synchronous; the bitmap memory needs no clearing pass.
// Input stalls only when both output entries are full.
module piece_bitmap_progress_parser #(
  parameter int MAP_BYTES   = 4096,
  parameter int CHUNK_BYTES = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // [2:0] status, [66:3] done_bytes, rest zero
);
  import pbpp_pkg::*;

  localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int LW = $clog2(MAP_BYTES + 1);
  localparam logic [32:0] MAP_LIMIT = 33'(MAP_BYTES);
  localparam logic [31:0] CHUNK = 32'(CHUNK_BYTES);

  // Parser state.
  phase_t      phase, phase_next;
  logic [31:0] field_count, field_count_next;
  logic [63:0] field_shift, field_shift_next;
  logic [31:0] piece_size, piece_size_next;
  logic [63:0] total_size, total_size_next;
  logic [63:0] byte_sum, byte_sum_next;
  logic [63:0] range_start, range_start_next;
  logic [LW-1:0] map_length, map_length_next;
  logic [31:0] entries_left, entries_left_next;
  logic [63:0] entry_bytes, entry_bytes_next;
  logic        entry_skip, entry_skip_next;
  logic [2:0]  fault, fault_next;

  // Looked-up completed bit of the current in-flight piece.
  logic [AW-1:0] eidx_addr, eidx_addr_next;
  logic [2:0]    eidx_bit, eidx_bit_next;
  logic          eidx_in_map, eidx_in_map_next;
  logic [7:0]    map_rd;
  logic [7:0]    completed_map [MAP_BYTES];
  logic          map_we;

  logic        accept;
  logic [63:0] val64;
  logic [31:0] val32;
  logic [31:0] fc_inc;
  logic        fin;
  logic [63:0] start_prod;
  logic [28:0] bi;
  logic [63:0] room;
  logic [63:0] clip_len;

  logic [63:0] sp_limit;
  logic [31:0] sp_step, sp_size;
  logic [7:0]  sp_bits;
  logic [34:0] sp_sum;
  logic [63:0] sp_next;
  logic [64:0] sum_raw;
  logic [63:0] sum_sat;

  logic [2:0]  res_status;
  logic [63:0] res_done;

  assign accept = s_tvalid && s_tready;
  assign val64  = {field_shift[55:0], s_tdata};
  assign val32  = val64[31:0];
  assign fc_inc = field_count + 32'd1;
  assign fin    = fc_inc >= {28'd0, field_width(phase)};
  assign start_prod = {32'd0, val32} * {32'd0, piece_size};
  assign bi     = val32[31:3];
  assign room   = total_size - range_start;
  assign clip_len = (range_start >= total_size) ? 64'd0 :
                    (({32'd0, val32} < room) ? {32'd0, val32} : room);

  // Span unit shared by the completed and in-flight bitmaps.
  always_comb begin
    if (phase == PH_MAP) begin
      sp_limit = total_size;
      sp_step  = piece_size;
      sp_size  = piece_size;
      sp_bits  = s_tdata;
    end else begin
      sp_limit = entry_bytes;
      sp_step  = CHUNK;
      sp_size  = CHUNK;
      sp_bits  = entry_skip ? 8'd0 : s_tdata;
    end
  end

  pbpp_span8 u_span (
    .base      (range_start),
    .step      (sp_step),
    .limit     (sp_limit),
    .size      (sp_size),
    .bits      (sp_bits),
    .sum       (sp_sum),
    .next_base (sp_next)
  );

  assign sum_raw = {1'b0, byte_sum} + {30'd0, sp_sum};
  assign sum_sat = sum_raw[64] ? '1 : sum_raw[63:0];

  // Next state for one accepted byte.
  always_comb begin
    phase_next        = phase;
    field_count_next  = field_count;
    field_shift_next  = field_shift;
    piece_size_next   = piece_size;
    total_size_next   = total_size;
    byte_sum_next     = byte_sum;
    range_start_next  = range_start;
    map_length_next   = map_length;
    entries_left_next = entries_left;
    entry_bytes_next  = entry_bytes;
    entry_skip_next   = entry_skip;
    fault_next        = fault;
    eidx_addr_next    = eidx_addr;
    eidx_bit_next     = eidx_bit;
    eidx_in_map_next  = eidx_in_map;
    map_we            = 1'b0;
    unique case (phase)
      PH_SINK: begin
      end
      PH_EXTSKIP, PH_HASHSKIP: begin
        field_count_next = field_count - 32'd1;
        if (field_count == 32'd1) begin
          phase_next       = (phase == PH_EXTSKIP) ? PH_HASHLEN : PH_PIECE;
          field_count_next = '0;
          field_shift_next = '0;
        end
      end
      PH_MAP: begin
        map_we           = ({{(33-LW){1'b0}}, map_length} < MAP_LIMIT);
        byte_sum_next    = sum_sat;
        range_start_next = sp_next;
        map_length_next  = map_length + LW'(1);
        field_count_next = field_count - 32'd1;
        if (field_count == 32'd1) begin
          phase_next       = PH_COUNT;
          field_count_next = '0;
          field_shift_next = '0;
        end
      end
      PH_EMAP: begin
        byte_sum_next    = sum_sat;
        range_start_next = sp_next;
        field_count_next = field_count - 32'd1;
        if (field_count == 32'd1) begin
          entries_left_next = entries_left - 32'd1;
          phase_next        = (entries_left == 32'd1) ? PH_SINK : PH_EIDX;
          field_count_next  = '0;
          field_shift_next  = '0;
        end
      end
      default: begin
        field_shift_next = val64;
        field_count_next = fc_inc;
        if (fin) begin
          field_count_next = '0;
          field_shift_next = '0;
          unique case (phase)
            PH_VERSION: begin
              if (val64 != 64'd1) begin
                fault_next = ST_VERSION;
                phase_next = PH_SINK;
              end else begin
                phase_next = PH_EXTLEN;
              end
            end
            PH_EXTLEN, PH_HASHLEN: begin
              if (val32 == 32'd0) begin
                phase_next = (phase == PH_EXTLEN) ? PH_HASHLEN : PH_PIECE;
              end else begin
                phase_next       = (phase == PH_EXTLEN) ? PH_EXTSKIP : PH_HASHSKIP;
                field_count_next = val32;
              end
            end
            PH_PIECE: begin
              if (val32 == 32'd0) begin
                fault_next = ST_ZERO_LEN;
                phase_next = PH_SINK;
              end else begin
                piece_size_next = val32;
                phase_next      = PH_TOTAL;
              end
            end
            PH_TOTAL: begin
              total_size_next = val64;
              phase_next      = PH_UPLOAD;
            end
            PH_UPLOAD: begin
              phase_next = PH_MAPLEN;
            end
            PH_MAPLEN: begin
              if ({1'b0, val32} > MAP_LIMIT) begin
                fault_next = ST_MAP_LARGE;
                phase_next = PH_SINK;
              end else begin
                map_length_next  = '0;
                range_start_next = '0;
                if (val32 == 32'd0) begin
                  phase_next = PH_COUNT;
                end else begin
                  phase_next       = PH_MAP;
                  field_count_next = val32;
                end
              end
            end
            PH_COUNT: begin
              entries_left_next = val32;
              phase_next        = (val32 == 32'd0) ? PH_SINK : PH_EIDX;
            end
            PH_EIDX: begin
              // The completed bit is read from memory through the registered lookup address and read port.
              eidx_addr_next   = bi[AW-1:0];
              eidx_bit_next    = val32[2:0];
              eidx_in_map_next = ({{(32-LW){1'b0}}, map_length} > {3'b000, bi});
              entry_skip_next  = (start_prod >= total_size);
              range_start_next = start_prod;
              phase_next       = PH_ELEN;
            end
            PH_ELEN: begin
              entry_bytes_next = clip_len;
              entry_skip_next  = entry_skip ||
                                 (eidx_in_map && map_rd[3'd7 - eidx_bit]);
              phase_next       = PH_EMLEN;
            end
            PH_EMLEN: begin
              range_start_next = '0;
              if (val32 == 32'd0) begin
                entries_left_next = entries_left - 32'd1;
                phase_next        = (entries_left == 32'd1) ? PH_SINK : PH_EIDX;
              end else begin
                phase_next       = PH_EMAP;
                field_count_next = val32;
              end
            end
            default: begin
              phase_next = PH_SINK;
            end
          endcase
        end
      end
    endcase
  end

  // Result of a last byte.
  always_comb begin
    if (phase_next == PH_SINK) begin
      res_status = fault_next;
    end else if (phase_next == PH_COUNT) begin
      res_status = ST_OK;
    end else begin
      res_status = ST_TRUNCATED;
    end
    res_done = '0;
    if (res_status == ST_OK) begin
      res_done = (byte_sum_next < total_size_next) ? byte_sum_next : total_size_next;
    end
  end

  // Parser registers; a last byte starts the next record afresh.
  always_ff @(posedge clk) begin
    if (rst || (accept && s_tlast)) begin
      phase        <= PH_VERSION;
      field_count  <= '0;
      field_shift  <= '0;
      piece_size   <= '0;
      total_size   <= '0;
      byte_sum     <= '0;
      range_start  <= '0;
      map_length   <= '0;
      entries_left <= '0;
      entry_bytes  <= '0;
      entry_skip   <= 1'b0;
      fault        <= ST_OK;
    end else if (accept) begin
      phase        <= phase_next;
      field_count  <= field_count_next;
      field_shift  <= field_shift_next;
      piece_size   <= piece_size_next;
      total_size   <= total_size_next;
      byte_sum     <= byte_sum_next;
      range_start  <= range_start_next;
      map_length   <= map_length_next;
      entries_left <= entries_left_next;
      entry_bytes  <= entry_bytes_next;
      entry_skip   <= entry_skip_next;
      fault        <= fault_next;
    end
  end

  // Lookup address of the in-flight piece.
  always_ff @(posedge clk) begin
    if (accept) begin
      eidx_addr   <= eidx_addr_next;
      eidx_bit    <= eidx_bit_next;
      eidx_in_map <= eidx_in_map_next;
    end
  end

  // Completed bitmap store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (accept && map_we) begin
      completed_map[map_length[AW-1:0]] <= s_tdata;
    end
    map_rd <= completed_map[eidx_addr];
  end

  // Two-entry output buffer.
  logic [1:0]  out_cnt;
  logic [66:0] out_head, out_tail, res_word;
  logic        push, pop;

  assign res_word = {res_done, res_status};
  assign push     = accept && s_tlast;
  assign pop      = m_tvalid && m_tready;
  assign s_tready = (out_cnt != 2'd2);
  assign m_tvalid = (out_cnt != 2'd0);
  assign m_tdata  = {5'd0, out_head};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= 2'd0;
    end else begin
      out_cnt <= out_cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (out_cnt == 2'd1) begin
        out_head <= res_word;
      end else begin
        out_head <= out_tail;
        out_tail <= res_word;
      end
    end else if (pop) begin
      out_head <= out_tail;
    end else if (push) begin
      if (out_cnt == 2'd0) begin
        out_head <= res_word;
      end else begin
        out_tail <= res_word;
      end
    end
  end

  // Checks on the output buffer and result contents.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) out_cnt != 2'd3)
    else $error("output buffer count out of range");
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    (out_cnt == 2'd2 && !pop) |=> out_cnt == 2'd2)
    else $error("full output buffer lost an entry");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= ST_MAP_LARGE)
    else $error("status code out of range");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2:0] != ST_OK) |-> m_tdata[66:3] == 64'd0)
    else $error("byte count given with an error status");

endmodule
